>>> src/ray_parallax_angle_unit_defines.svh
// Assertion macros shared by the ray parallax angle unit.
`ifndef RAY_PARALLAX_ANGLE_UNIT_DEFINES_SVH
`define RAY_PARALLAX_ANGLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rpa_pkg.sv
// Shared types, constants and tables of the ray parallax angle unit.
`default_nettype none

package rpa_pkg;

    localparam int SQ_STAGES    = 32;
    localparam int DIV_STAGES   = 31;
    localparam int CORDIC_STEPS = 23;

    localparam logic [15:0] ANGLE_MAX = 16'd46080;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd3;

    localparam logic [15:0] RST_FOCAL_X  = 16'd8000;
    localparam logic [15:0] RST_FOCAL_Y  = 16'd8000;
    localparam logic [15:0] RST_CENTER_X = 16'd5120;
    localparam logic [15:0] RST_CENTER_Y = 16'd3840;

    // Arctangent of 2^-i in Q16 degrees.
    localparam logic [23:0] ATAN_Q16 [0:CORDIC_STEPS-1] = '{
        24'd2949120, 24'd1740967, 24'd919879, 24'd466945, 24'd234379, 24'd117304,
        24'd58666, 24'd29335, 24'd14668, 24'd7334, 24'd3667, 24'd1833, 24'd917,
        24'd458, 24'd229, 24'd115, 24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2, 24'd1
    };

    typedef logic signed [31:0] t_unit;

    typedef struct packed {
        logic [15:0] focal_x;
        logic [15:0] focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
    } t_cfg;

endpackage

`default_nettype wire

>>> src/rpa_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module rpa_sqrt
    import rpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_n,
    output logic             o_valid,
    output logic [31:0]      o_root
);

    logic [63:0] r_n   [0:SQ_STAGES-1];
    logic [35:0] r_rem [0:SQ_STAGES-1];
    logic [31:0] r_q   [0:SQ_STAGES-1];
    logic        r_v   [0:SQ_STAGES-1];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        logic [63:0] n_in;
        logic [35:0] rem_in;
        logic [31:0] q_in;
        logic        v_in;
        logic [35:0] acc;
        logic [35:0] trial;
        logic        take;

        if (k == 0) begin : g_first
            assign n_in   = i_n;
            assign rem_in = '0;
            assign q_in   = '0;
            assign v_in   = i_valid;
        end else begin : g_next
            assign n_in   = r_n[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign v_in   = r_v[k-1];
        end

        always_comb begin
            acc   = {rem_in[33:0], n_in[63:62]};
            trial = {2'b00, q_in, 2'b01};
            take  = (acc >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]   <= {n_in[61:0], 2'b00};
                r_rem[k] <= take ? (acc - trial) : acc;
                r_q[k]   <= {q_in[30:0], take};
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_q[SQ_STAGES-1];

endmodule

`default_nettype wire

>>> src/rpa_div.sv
// Pipelined restoring divider giving floor(mag * 2^30 / den), one quotient bit per stage.
`default_nettype none

module rpa_div
    import rpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [23:0] i_mag,
    input  wire logic [25:0] i_den,
    output logic             o_valid,
    output logic [30:0]      o_quo
);

    logic [26:0] r_rem [0:DIV_STAGES-1];
    logic [25:0] r_den [0:DIV_STAGES-1];
    logic [30:0] r_q   [0:DIV_STAGES-1];
    logic        r_v   [0:DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [26:0] trial;
        logic [26:0] den_x;
        logic [25:0] den_in;
        logic [30:0] q_in;
        logic        v_in;
        logic        take;

        if (k == 0) begin : g_first
            // The magnitude never exceeds the divisor, so one compare gives the top bit.
            assign trial  = {3'b000, i_mag};
            assign den_in = i_den;
            assign q_in   = '0;
            assign v_in   = i_valid;
        end else begin : g_next
            assign trial  = {r_rem[k-1][25:0], 1'b0};
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
            assign v_in   = r_v[k-1];
        end

        always_comb begin
            den_x = {1'b0, den_in};
            take  = (trial >= den_x);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? (trial - den_x) : trial;
                r_den[k] <= den_in;
                r_q[k]   <= {q_in[29:0], take};
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quo   = r_q[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/rpa_ray.sv
// Back-projection, rotation and normalization of one keypoint ray to Q30 unit components.
`default_nettype none

module rpa_ray
    import rpa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_cfg        i_cfg,
    input  wire logic [15:0] i_px_x,
    input  wire logic [15:0] i_px_y,
    input  wire logic [47:0] i_row0,
    input  wire logic [47:0] i_row1,
    input  wire logic [47:0] i_row2,
    output logic             o_valid,
    output logic             o_zero,
    output t_unit            o_u0,
    output t_unit            o_u1,
    output t_unit            o_u2
);

    localparam int SIDE_W = 76;

    logic [9:0] r_vld;

    // Stage 1: offsets and guarded focal lengths.
    logic signed [16:0] r_dx, r_dy;
    logic [15:0]        r_fx, r_fy;
    logic [47:0]        r_row1 [0:2];
    // Stage 2: scaled ray.
    logic signed [33:0] r_r [0:2];
    logic [47:0]        r_row2 [0:2];
    // Stage 3: rotation products.
    logic signed [49:0] r_p [0:2][0:2];
    // Stage 4: world ray.
    logic signed [51:0] r_w [0:2];
    // Stage 5 to 7: magnitudes and leading one search.
    logic [50:0]        r_mag5 [0:2];
    logic [50:0]        r_mag6 [0:2];
    logic [50:0]        r_mag7 [0:2];
    logic [2:0]         r_sgn5, r_sgn6, r_sgn7, r_sgn8, r_sgn9, r_sgn10;
    logic [50:0]        r_or;
    logic [6:0]         r_nz;
    logic [2:0]         r_loc [0:6];
    logic [5:0]         r_pos;
    logic               r_zero7, r_zero8, r_zero9, r_zero10;
    // Stage 8 to 10: scaled magnitudes and squared norm.
    logic [23:0]        r_sm8 [0:2];
    logic [23:0]        r_sm9 [0:2];
    logic [23:0]        r_sm10 [0:2];
    logic [47:0]        r_sq [0:2];
    logic [49:0]        r_norm;

    logic [47:0] rows_in [0:2];

    assign rows_in[0] = i_row0;
    assign rows_in[1] = i_row1;
    assign rows_in[2] = i_row2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[8:0], i_valid};
        end
    end

    // Combinational parts of stages 5 to 8.
    logic [50:0] n_mag [0:2];
    logic [2:0]  n_sgn;
    logic [55:0] grp_bits;
    logic [6:0]  n_nz;
    logic [2:0]  n_loc [0:6];
    logic [5:0]  n_pos;
    logic        n_zero;
    logic [23:0] n_sm [0:2];

    always_comb begin
        logic signed [51:0] neg;
        logic [50:0]        shr;
        logic [50:0]        shl;
        for (int j = 0; j < 3; j++) begin
            neg      = -r_w[j];
            n_sgn[j] = r_w[j][51];
            n_mag[j] = r_w[j][51] ? neg[50:0] : r_w[j][50:0];
        end
        grp_bits = {5'b00000, r_or};
        for (int g = 0; g < 7; g++) begin
            n_nz[g]  = |grp_bits[8*g +: 8];
            n_loc[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (grp_bits[8*g + b]) begin
                    n_loc[g] = 3'(b);
                end
            end
        end
        n_pos  = '0;
        n_zero = ~|r_nz;
        for (int g = 0; g < 7; g++) begin
            if (r_nz[g]) begin
                n_pos = {3'(g), r_loc[g]};
            end
        end
        for (int j = 0; j < 3; j++) begin
            shr     = r_mag7[j] >> (r_pos - 6'd23);
            shl     = r_mag7[j] << (6'd23 - r_pos);
            n_sm[j] = (r_pos >= 6'd23) ? shr[23:0] : shl[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= $signed({1'b0, i_px_x}) - $signed({1'b0, i_cfg.center_x});
            r_dy <= $signed({1'b0, i_px_y}) - $signed({1'b0, i_cfg.center_y});
            r_fx <= (i_cfg.focal_x == '0) ? 16'd1 : i_cfg.focal_x;
            r_fy <= (i_cfg.focal_y == '0) ? 16'd1 : i_cfg.focal_y;
            for (int i = 0; i < 3; i++) begin
                r_row1[i] <= rows_in[i];
                r_row2[i] <= r_row1[i];
            end

            r_r[0] <= r_dx * $signed({1'b0, r_fy});
            r_r[1] <= r_dy * $signed({1'b0, r_fx});
            r_r[2] <= $signed({2'b00, 32'(r_fx) * 32'(r_fy)});

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i][j] <= $signed(r_row2[i][16*j +: 16]) * r_r[i];
                end
            end

            for (int j = 0; j < 3; j++) begin
                r_w[j] <= r_p[0][j] + r_p[1][j] + r_p[2][j];
            end

            r_mag5 <= n_mag;
            r_sgn5 <= n_sgn;
            r_or   <= n_mag[0] | n_mag[1] | n_mag[2];

            r_mag6 <= r_mag5;
            r_sgn6 <= r_sgn5;
            r_nz   <= n_nz;
            r_loc  <= n_loc;

            r_mag7  <= r_mag6;
            r_sgn7  <= r_sgn6;
            r_pos   <= n_pos;
            r_zero7 <= n_zero;

            r_sm8   <= n_sm;
            r_sgn8  <= r_sgn7;
            r_zero8 <= r_zero7;

            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= 48'(r_sm8[j]) * 48'(r_sm8[j]);
            end
            r_sm9   <= r_sm8;
            r_sgn9  <= r_sgn8;
            r_zero9 <= r_zero8;

            r_norm   <= 50'(r_sq[0]) + 50'(r_sq[1]) + 50'(r_sq[2]);
            r_sm10   <= r_sm9;
            r_sgn10  <= r_sgn9;
            r_zero10 <= r_zero9;
        end
    end

    // Square root of the norm, with the components riding alongside.
    logic        sq_valid;
    logic [31:0] sq_root;

    rpa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vld[9]),
        .i_n     ({14'b0, r_norm}),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    logic [SIDE_W-1:0] r_sq_side [0:SQ_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_side[0] <= {r_sgn10, r_zero10, r_sm10[0], r_sm10[1], r_sm10[2]};
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    logic [SIDE_W-1:0] sq_side;
    logic [23:0]       div_mag [0:2];

    assign sq_side    = r_sq_side[SQ_STAGES-1];
    assign div_mag[0] = sq_side[71:48];
    assign div_mag[1] = sq_side[47:24];
    assign div_mag[2] = sq_side[23:0];

    logic        div_valid [0:2];
    logic [30:0] div_quo   [0:2];

    for (genvar j = 0; j < 3; j++) begin : g_div
        rpa_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (sq_valid),
            .i_mag   (div_mag[j]),
            .i_den   (sq_root[25:0]),
            .o_valid (div_valid[j]),
            .o_quo   (div_quo[j])
        );
    end

    logic [3:0] r_div_side [0:DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div_side[0] <= sq_side[75:72];
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_div_side[k] <= r_div_side[k-1];
            end
        end
    end

    logic [3:0] div_side;
    logic       r_vout;
    logic       r_zero;
    t_unit      r_u [0:2];

    assign div_side = r_div_side[DIV_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_vout <= div_valid[0] & div_valid[1] & div_valid[2];
        end
    end

    // Bit 0 of the side word is the zero flag; bit j+1 is the sign of component j.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= div_side[0];
            for (int j = 0; j < 3; j++) begin
                r_u[j] <= div_side[j+1] ? -$signed({1'b0, div_quo[j]})
                                        : $signed({1'b0, div_quo[j]});
            end
        end
    end

    assign o_valid = r_vout;
    assign o_zero  = r_zero;
    assign o_u0    = r_u[0];
    assign o_u1    = r_u[1];
    assign o_u2    = r_u[2];

endmodule

`default_nettype wire

>>> src/rpa_angle.sv
// Cosine, sine and pipelined CORDIC arctangent of the two unit rays, in Q8.8 degrees.
`default_nettype none

module rpa_angle
    import rpa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire logic  i_zero,
    input  wire t_unit i_a0,
    input  wire t_unit i_a1,
    input  wire t_unit i_a2,
    input  wire t_unit i_b0,
    input  wire t_unit i_b1,
    input  wire t_unit i_b2,
    output logic        o_valid,
    output logic [15:0] o_angle_deg,
    output logic        o_clamped
);

    localparam logic signed [25:0] Z_RIGHT = 26'sd5898240;
    localparam logic [30:0]        ONE_Q30 = 31'h4000_0000;
    localparam int                 SIDE_W  = 34;

    logic [4:0] r_vld;

    logic signed [63:0] r_prod [0:2];
    logic signed [63:0] r_dot;
    logic [30:0]        r_cmag3, r_cmag4, r_cmag5;
    logic               r_cneg3, r_cneg4, r_cneg5;
    logic               r_clmp3, r_clmp4, r_clmp5;
    logic [61:0]        r_csq;
    logic [60:0]        r_diff;
    logic               r_zero1, r_zero2, r_zero3, r_zero4, r_zero5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // Dot product truncated toward zero, then clamped into [-1, 1].
    logic [30:0] n_cmag;
    logic        n_clmp;

    always_comb begin
        logic signed [63:0] neg;
        logic [63:0]        mag;
        logic [33:0]        q;
        neg = -r_dot;
        mag = r_dot[63] ? neg : r_dot;
        q   = mag[63:30];
        if (q > 34'(ONE_Q30)) begin
            n_cmag = ONE_Q30;
            n_clmp = 1'b1;
        end else begin
            n_cmag = q[30:0];
            n_clmp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[0] <= i_a0 * i_b0;
            r_prod[1] <= i_a1 * i_b1;
            r_prod[2] <= i_a2 * i_b2;
            r_zero1   <= i_zero;

            r_dot   <= r_prod[0] + r_prod[1] + r_prod[2];
            r_zero2 <= r_zero1;

            r_cmag3 <= n_cmag;
            r_cneg3 <= r_dot[63] && (n_cmag != '0);
            r_clmp3 <= n_clmp;
            r_zero3 <= r_zero2;

            r_csq   <= 62'(r_cmag3) * 62'(r_cmag3);
            r_cmag4 <= r_cmag3;
            r_cneg4 <= r_cneg3;
            r_clmp4 <= r_clmp3;
            r_zero4 <= r_zero3;

            r_diff  <= 61'(62'h1000_0000_0000_0000 - r_csq);
            r_cmag5 <= r_cmag4;
            r_cneg5 <= r_cneg4;
            r_clmp5 <= r_clmp4;
            r_zero5 <= r_zero4;
        end
    end

    logic        sq_valid;
    logic [31:0] sq_root;

    rpa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_vld[4]),
        .i_n     ({3'b000, r_diff}),
        .o_valid (sq_valid),
        .o_root  (sq_root)
    );

    logic [SIDE_W-1:0] r_side [0:SQ_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= {r_cneg5, r_clmp5, r_zero5, r_cmag5};
            for (int k = 1; k < SQ_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic [SIDE_W-1:0] side;

    assign side = r_side[SQ_STAGES-1];

    // CORDIC vectoring: index 0 holds the start vector, index k+1 the result of step k.
    logic signed [33:0] r_x  [0:CORDIC_STEPS];
    logic signed [33:0] r_y  [0:CORDIC_STEPS];
    logic signed [25:0] r_z  [0:CORDIC_STEPS];
    logic               r_cl [0:CORDIC_STEPS];
    logic               r_zr [0:CORDIC_STEPS];
    logic               r_cv [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (i_en) begin
            r_cv[0] <= sq_valid;
        end
    end

    // A negative cosine starts a right angle on, with the vector turned back.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= side[33] ? $signed({2'b00, sq_root}) : $signed({3'b000, side[30:0]});
            r_y[0]  <= side[33] ? $signed({3'b000, side[30:0]}) : $signed({2'b00, sq_root});
            r_z[0]  <= side[33] ? Z_RIGHT : 26'sd0;
            r_cl[0] <= side[32];
            r_zr[0] <= side[31];
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        logic signed [25:0] step;

        assign step = $signed({2'b00, ATAN_Q16[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_cv[k+1] <= r_cv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] > 34'sd0) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + step;
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - step;
                end
                r_cl[k+1] <= r_cl[k];
                r_zr[k+1] <= r_zr[k];
            end
        end
    end

    // Round Q16 to Q8 and saturate; a degenerate ray forces zero and the flag.
    logic [15:0] n_angle;
    logic        n_clamped;

    always_comb begin
        logic signed [26:0] zt;
        logic signed [26:0] zs;
        zt = 27'(r_z[CORDIC_STEPS]) + 27'sd128;
        zs = zt >>> 8;
        if (r_zr[CORDIC_STEPS]) begin
            n_angle   = '0;
            n_clamped = 1'b1;
        end else begin
            n_clamped = r_cl[CORDIC_STEPS];
            if (zs < 27'sd0) begin
                n_angle = '0;
            end else if (zs > $signed({11'b0, ANGLE_MAX})) begin
                n_angle = ANGLE_MAX;
            end else begin
                n_angle = zs[15:0];
            end
        end
    end

    logic        r_vout;
    logic [15:0] r_angle;
    logic        r_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (i_en) begin
            r_vout <= r_cv[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle   <= n_angle;
            r_clamped <= n_clamped;
        end
    end

    assign o_valid     = r_vout;
    assign o_angle_deg = r_angle;
    assign o_clamped   = r_clamped;

endmodule

`default_nettype wire

>>> src/ray_parallax_angle_unit.sv
// Top level of the ray parallax angle unit: configuration registers, two ray lanes, angle pipe.
// Pipeline: every item passes 136 register stages, the last of them the output register.
// Throughput: one item per cycle; the whole pipe advances together whenever the output
// register is empty or its result is taken in the same cycle.
// Reset: i_rst_n is synchronous and active low; it empties the pipe and loads the default
// intrinsics (focal lengths 500.0, principal point 320.0 by 240.0).
`default_nettype none

`include "ray_parallax_angle_unit_defines.svh"

module ray_parallax_angle_unit
    import rpa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,

    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [15:0]          i_first_px_x,
    input  wire logic [15:0]          i_first_px_y,
    input  wire logic [15:0]          i_second_px_x,
    input  wire logic [15:0]          i_second_px_y,
    input  wire logic [47:0]          i_first_rot_row0,
    input  wire logic [47:0]          i_first_rot_row1,
    input  wire logic [47:0]          i_first_rot_row2,
    input  wire logic [47:0]          i_second_rot_row0,
    input  wire logic [47:0]          i_second_rot_row1,
    input  wire logic [47:0]          i_second_rot_row2,

    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [15:0]               o_angle_deg,
    output logic                      o_clamped
);

    // Configuration registers, read directly by the lanes. Writes must arrive only while the
    // pipe is empty; the block does not enforce it. Indexes past the last are taken and dropped.
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x  <= RST_FOCAL_X;
            r_cfg.focal_y  <= RST_FOCAL_Y;
            r_cfg.center_x <= RST_CENTER_X;
            r_cfg.center_y <= RST_CENTER_Y;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FOCAL_X:  r_cfg.focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_cfg.focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_cfg.center_x <= i_cfg_data;
                CFG_CENTER_Y: r_cfg.center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One enable for every stage. The output register of the angle pipe doubles as the
    // boundary between the two sides: a new transfer is taken in the same cycle in which
    // the waiting result leaves.
    logic pipe_en;
    logic in_xfer;

    assign pipe_en    = !o_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;
    assign in_xfer    = i_in_valid && pipe_en;

    // The two rays run in identical lanes, so their results line up stage for stage.
    logic  ray_a_valid, ray_b_valid;
    logic  ray_a_zero, ray_b_zero;
    t_unit ua0, ua1, ua2, ub0, ub1, ub2;

    rpa_ray u_ray_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (in_xfer),
        .i_cfg   (r_cfg),
        .i_px_x  (i_first_px_x),
        .i_px_y  (i_first_px_y),
        .i_row0  (i_first_rot_row0),
        .i_row1  (i_first_rot_row1),
        .i_row2  (i_first_rot_row2),
        .o_valid (ray_a_valid),
        .o_zero  (ray_a_zero),
        .o_u0    (ua0),
        .o_u1    (ua1),
        .o_u2    (ua2)
    );

    rpa_ray u_ray_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (in_xfer),
        .i_cfg   (r_cfg),
        .i_px_x  (i_second_px_x),
        .i_px_y  (i_second_px_y),
        .i_row0  (i_second_rot_row0),
        .i_row1  (i_second_rot_row1),
        .i_row2  (i_second_rot_row2),
        .o_valid (ray_b_valid),
        .o_zero  (ray_b_zero),
        .o_u0    (ub0),
        .o_u1    (ub1),
        .o_u2    (ub2)
    );

    // Either ray being all zero makes the angle meaningless; the angle pipe reports zero
    // degrees with the clamp flag set in that case.
    rpa_angle u_angle (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_valid     (ray_a_valid && ray_b_valid),
        .i_zero      (ray_a_zero || ray_b_zero),
        .i_a0        (ua0),
        .i_a1        (ua1),
        .i_a2        (ua2),
        .i_b0        (ub0),
        .i_b1        (ub1),
        .i_b2        (ub2),
        .o_valid     (o_out_valid),
        .o_angle_deg (o_angle_deg),
        .o_clamped   (o_clamped)
    );

    `RPA_ASSERT_NOW(a_angle_range, o_out_valid, o_angle_deg <= ANGLE_MAX, "angle above 180 degrees")
    `RPA_ASSERT_NEXT(a_stall_hold, !o_in_ready, o_out_valid && $stable(o_angle_deg) && $stable(o_clamped), "result changed during stall")
    `RPA_ASSERT_NEXT(a_cfg_fx, i_cfg_valid && i_cfg_index == CFG_FOCAL_X, r_cfg.focal_x == $past(i_cfg_data), "focal_x write lost")

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the ray parallax angle unit with a built-in angle predictor.
`default_nettype none

module tb
    import rpa_pkg::*;
();

    typedef struct {
        logic [15:0] p1x, p1y, p2x, p2y;
        logic [47:0] ra0, ra1, ra2, rb0, rb1, rb2;
    } t_pair;

    typedef struct {
        logic [15:0] angle;
        logic        clamped;
    } t_angle;

    // Scoreboard: keeps its own copy of the intrinsics, predicts the angle of every
    // accepted keypoint pair and checks results in arrival order.
    class t_angle_board;
        longint unsigned fx, fy, cx, cy;
        t_angle          want_q[$];
        int              errors;
        longint          atan_tab[23] = '{
            2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

        function new();
            fx = 8000; fy = 8000; cx = 5120; cy = 3840;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_FOCAL_X:  fx = val;
                CFG_FOCAL_Y:  fy = val;
                CFG_CENTER_X: cx = val;
                CFG_CENTER_Y: cy = val;
                default: ;
            endcase
        endfunction

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Returns 0 for a ray that the rotation collapses to zero.
        function bit unit_ray(logic [15:0] px, logic [15:0] py, logic [47:0] r0,
                              logic [47:0] r1, logic [47:0] r2, output longint u[3]);
            longint fxs, fys, cam[3], w[3], m, n, s;
            logic [47:0] rows[3];
            rows[0] = r0; rows[1] = r1; rows[2] = r2;
            fxs = (fx == 0) ? 1 : longint'(fx);
            fys = (fy == 0) ? 1 : longint'(fy);
            cam[0] = (longint'(px) - longint'(cx)) * fys;
            cam[1] = (longint'(py) - longint'(cy)) * fxs;
            cam[2] = fxs * fys;
            m = 0;
            for (int j = 0; j < 3; j++) begin
                w[j] = 0;
                for (int i = 0; i < 3; i++)
                    w[j] += longint'($signed(rows[i][16*j +: 16])) * cam[i];
                if ((w[j] < 0 ? -w[j] : w[j]) > m) m = (w[j] < 0 ? -w[j] : w[j]);
            end
            if (m == 0) return 0;
            // Bring the largest component into [2^23, 2^24), truncating magnitudes.
            while (m >= (64'sd1 << 24)) begin
                m >>= 1;
                for (int j = 0; j < 3; j++)
                    w[j] = (w[j] < 0) ? -((-w[j]) >> 1) : (w[j] >> 1);
            end
            while (m < (64'sd1 << 23)) begin
                m <<= 1;
                for (int j = 0; j < 3; j++) w[j] *= 2;
            end
            n = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
            s = longint'(isqrt(n));
            for (int j = 0; j < 3; j++) u[j] = (w[j] * (64'sd1 << 30)) / s;
            return 1;
        endfunction

        function void note_pair(t_pair p);
            longint u1[3], u2[3], c, x, y, z, nx;
            t_angle a;
            a.clamped = 0;
            if (!unit_ray(p.p1x, p.p1y, p.ra0, p.ra1, p.ra2, u1) ||
                !unit_ray(p.p2x, p.p2y, p.rb0, p.rb1, p.rb2, u2)) begin
                a.angle = 0;
                a.clamped = 1;
                want_q.insert(want_q.size(), a);
                return;
            end
            c = (u1[0]*u2[0] + u1[1]*u2[1] + u1[2]*u2[2]) / (64'sd1 << 30);
            if (c > (64'sd1 << 30)) begin
                c = 64'sd1 << 30; a.clamped = 1;
            end else if (c < -(64'sd1 << 30)) begin
                c = -(64'sd1 << 30); a.clamped = 1;
            end
            if (c >= 0) begin
                x = c; y = longint'(isqrt((64'd1 << 60) - c*c)); z = 0;
            end else begin
                x = longint'(isqrt((64'd1 << 60) - c*c)); y = -c; z = 90 * 65536;
            end
            // Vectoring CORDIC drives y to zero and accumulates the angle in z.
            for (int i = 0; i < 23; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
                end else begin
                    nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
                end
                x = nx;
            end
            z = (z + 128) >>> 8;
            if (z < 0) z = 0;
            if (z > 46080) z = 46080;
            a.angle = z[15:0];
            want_q.insert(want_q.size(), a);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_angle(logic [15:0] angle, logic clamped);
            t_angle a;
            if (want_q.size() == 0) begin
                report($sformatf("unexpected result angle=%0d", angle));
                return;
            end
            a = want_q.pop_front();
            if (angle !== a.angle)
                report($sformatf("angle got %0d want %0d", angle, a.angle));
            if (clamped !== a.clamped)
                report($sformatf("clamped got %0d want %0d", clamped, a.clamped));
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;
    logic                 i_in_valid = 0;
    logic                 o_in_ready;
    logic [15:0]          i_first_px_x = 0, i_first_px_y = 0;
    logic [15:0]          i_second_px_x = 0, i_second_px_y = 0;
    logic [47:0]          i_first_rot_row0 = 0, i_first_rot_row1 = 0, i_first_rot_row2 = 0;
    logic [47:0]          i_second_rot_row0 = 0, i_second_rot_row1 = 0, i_second_rot_row2 = 0;
    logic                 o_out_valid;
    logic                 i_out_ready = 0;
    logic [15:0]          o_angle_deg;
    logic                 o_clamped;

    ray_parallax_angle_unit i_dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    t_angle_board board = new();
    int send_idle_pct = 25;
    int recv_idle_pct = 63;
    int hold_cycles   = 0;
    int quiet_cycles  = 0;

    // The receiver decides its ready at each falling edge; a hold-off overrides it.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every transfer is sampled at the rising edge; input transfers feed the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                board.note_pair('{i_first_px_x, i_first_px_y, i_second_px_x, i_second_px_y,
                                  i_first_rot_row0, i_first_rot_row1, i_first_rot_row2,
                                  i_second_rot_row0, i_second_rot_row1, i_second_rot_row2});
            if (o_out_valid && i_out_ready)
                board.check_angle(o_angle_deg, o_clamped);
        end
    end

    // Watchdog: the run ends if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one pair, after a random idle gap, and waits for its transfer.
    // Valid is left high on return so back-to-back pairs never glitch it.
    task send_pair(t_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 0;
        end
        @(negedge i_clk);
        i_in_valid        <= 1;
        i_first_px_x      <= p.p1x;  i_first_px_y      <= p.p1y;
        i_second_px_x     <= p.p2x;  i_second_px_y     <= p.p2y;
        i_first_rot_row0  <= p.ra0;  i_first_rot_row1  <= p.ra1;  i_first_rot_row2  <= p.ra2;
        i_second_rot_row0 <= p.rb0;  i_second_rot_row1 <= p.rb1;  i_second_rot_row2 <= p.rb2;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Lowers valid and waits until every predicted result has been checked,
    // then lets the pipe settle for its full depth.
    task drain;
        @(negedge i_clk);
        i_in_valid <= 0;
        while (board.want_q.size() != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task set_intrinsics(logic [15:0] f_x, logic [15:0] f_y, logic [15:0] c_x,
                        logic [15:0] c_y);
        write_reg(CFG_FOCAL_X, f_x);
        write_reg(CFG_FOCAL_Y, f_y);
        write_reg(CFG_CENTER_X, c_x);
        write_reg(CFG_CENTER_Y, c_y);
    endtask

    function automatic logic [47:0] rot_row(int a, int b, int c);
        return {16'(c), 16'(b), 16'(a)};
    endfunction

    // A rotation that is either full noise, a signed axis permutation, or a
    // signed diagonal matrix with small perturbations.
    function automatic void pick_rotation(output logic [47:0] r0, r1, r2);
        int mode, pm, sg[3], nz;
        mode = $urandom_range(9);
        if (mode < 3) begin
            r0 = 48'({$urandom, $urandom});
            r1 = 48'({$urandom, $urandom});
            r2 = 48'({$urandom, $urandom});
        end else begin
            nz = (mode < 6) ? 0 : 600;
            for (int k = 0; k < 3; k++) sg[k] = ($urandom_range(1) != 0) ? 16384 : -16384;
            pm = (mode < 6) ? $urandom_range(2) : 0;
            r0 = rot_row(pm == 0 ? sg[0] : 0, pm == 1 ? sg[0] : 0, pm == 2 ? sg[0] : 0);
            r1 = rot_row(pm == 2 ? sg[1] : 0, pm == 0 ? sg[1] : 0, pm == 1 ? sg[1] : 0);
            r2 = rot_row(pm == 1 ? sg[2] : 0, pm == 2 ? sg[2] : 0, pm == 0 ? sg[2] : 0);
            if (nz != 0) begin
                r0 += rot_row($urandom_range(2*nz) - nz, $urandom_range(2*nz) - nz,
                              $urandom_range(2*nz) - nz);
                r1 += rot_row($urandom_range(2*nz) - nz, $urandom_range(2*nz) - nz,
                              $urandom_range(2*nz) - nz);
                r2 += rot_row($urandom_range(2*nz) - nz, $urandom_range(2*nz) - nz,
                              $urandom_range(2*nz) - nz);
            end
        end
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        if ($urandom_range(1) != 0) begin
            p.p1x = 16'($urandom); p.p1y = 16'($urandom);
            p.p2x = 16'($urandom); p.p2y = 16'($urandom);
        end else begin
            p.p1x = 16'(16'd5120 + $urandom_range(2000) - 1000);
            p.p1y = 16'(16'd3840 + $urandom_range(2000) - 1000);
            p.p2x = 16'(p.p1x + $urandom_range(40) - 20);
            p.p2y = 16'(p.p1y + $urandom_range(40) - 20);
        end
        pick_rotation(p.ra0, p.ra1, p.ra2);
        if ($urandom_range(3) == 0) begin
            p.rb0 = p.ra0; p.rb1 = p.ra1; p.rb2 = p.ra2;
        end else begin
            pick_rotation(p.rb0, p.rb1, p.rb2);
        end
        return p;
    endfunction

    initial begin
        t_pair p;
        logic [47:0] eye0, eye1, eye2, neg0, neg1, neg2, big;
        int n_items;

        eye0 = rot_row(16384, 0, 0); eye1 = rot_row(0, 16384, 0); eye2 = rot_row(0, 0, 16384);
        neg0 = rot_row(-16384, 0, 0); neg1 = rot_row(0, -16384, 0);
        neg2 = rot_row(0, 0, -16384);
        big  = 48'h8000_8000_8000;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed pairs at the reset intrinsics.
        // Same pixel and same rotation: zero angle, possibly clamped by rounding.
        send_pair('{5120, 3840, 5120, 3840, eye0, eye1, eye2, eye0, eye1, eye2});
        send_pair('{0, 0, 65535, 65535, eye0, eye1, eye2, eye0, eye1, eye2});
        send_pair('{65535, 0, 0, 65535, eye0, eye1, eye2, eye0, eye1, eye2});
        // Opposite rays: the negative cosine branch at its extreme.
        send_pair('{5120, 3840, 5120, 3840, eye0, eye1, eye2, neg0, neg1, neg2});
        send_pair('{100, 200, 9000, 7000, eye0, eye1, eye2, neg0, neg1, neg2});
        // Degenerate all-zero rotations on either side.
        send_pair('{1000, 1000, 2000, 2000, 0, 0, 0, eye0, eye1, eye2});
        send_pair('{1000, 1000, 2000, 2000, eye0, eye1, eye2, 0, 0, 0});
        // Most negative entries and all-ones rows.
        send_pair('{65535, 65535, 0, 0, big, big, big, eye0, eye1, eye2});
        send_pair('{0, 65535, 65535, 0, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                    big, eye1, eye2});
        send_pair('{5120, 3840, 5121, 3840, eye0, eye1, eye2, eye0, eye1, eye2});
        drain();

        // Zero focal lengths act as one; a write beyond the last register is ignored.
        set_intrinsics(0, 0, 0, 0);
        write_reg(3'd5, 16'hFFFF);
        send_pair('{0, 0, 65535, 65535, eye0, eye1, eye2, eye0, eye1, eye2});
        send_pair('{1, 1, 0, 0, eye0, eye1, eye2, neg0, neg1, neg2});
        send_pair('{65535, 0, 65535, 0, big, eye1, eye2, eye0, big, eye2});
        drain();
        set_intrinsics(65535, 65535, 65535, 65535);
        send_pair('{0, 0, 65535, 65535, eye0, eye1, eye2, eye0, eye1, eye2});
        send_pair('{0, 65535, 65535, 0, eye0, eye1, eye2, neg0, neg1, neg2});
        drain();

        // Random part over several intrinsics settings and three idling regimes.
        n_items = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_intrinsics(8000, 8000, 5120, 3840);
                1: set_intrinsics(1, 1, 0, 0);
                2: set_intrinsics(65535, 1, 65535, 0);
                3: set_intrinsics(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                4: set_intrinsics(0, 65535, 32768, 65535);
                default: set_intrinsics(8000, 6000, 5120, 3840);
            endcase
            if (phase < 2) begin
                send_idle_pct = 25; recv_idle_pct = 63;
            end else if (phase < 4) begin
                send_idle_pct = 63; recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            for (int k = 0; k < 255; k++) begin
                // A long receiver stall fills the pipe and back-pressures the input.
                if (phase == 4 && k == 20) hold_cycles = 400;
                // One pause of the sender until the pipe has emptied.
                if (phase == 5 && k == 100) drain();
                send_pair(random_pair());
                n_items++;
            end
            drain();
        end

        if (board.errors == 0 && board.want_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire
